[hdl/window_median_select_top_assert.svh]
// assertion macros for the checker file wms_checker.sv
// no dependencies
`ifndef WINDOW_MEDIAN_SELECT_TOP_ASSERT_SVH
`define WINDOW_MEDIAN_SELECT_TOP_ASSERT_SVH

// implication checked at every clock edge outside reset
`define WMS_ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property that also holds during reset
`define WMS_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/wms_pkg.sv]
// shared types for the window median select block
// no dependencies
package wms_pkg;

	localparam int unsigned IN_VALUE_W  = 16;
	localparam int unsigned OUT_COUNT_W = 6;

	typedef struct packed {
		logic [IN_VALUE_W-1:0] value;
		logic                  last;
	} in_t;

	typedef struct packed {
		logic [IN_VALUE_W-1:0]  median;
		logic [OUT_COUNT_W-1:0] count;
		logic                   overflow;
	} out_t;

	// status handed from one sorting cell to the next
	typedef struct packed {
		logic occupied;
		logic greater;
	} link_t;

endpackage

[hdl/wms_cell.sv]
// one cell of the sorting chain: holds one entry of the sorted store
// depends on wms_pkg
module wms_cell #(
	parameter int unsigned VALUE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic                  occupied,
	input  logic [VALUE_BITS-1:0] v,
	input  wms_pkg::link_t        prev_link,
	input  logic [VALUE_BITS-1:0] prev_value,
	output wms_pkg::link_t        link,
	output logic [VALUE_BITS-1:0] value_q
);
	import wms_pkg::*;

	logic greater;
	logic shift;

	assign greater = occupied & (value_q > v);
	// take a new entry if ours moves up, or if we are the first free cell
	assign shift   = greater | (~occupied & prev_link.occupied);

	assign link.occupied = occupied;
	assign link.greater  = greater;

	always_ff @(posedge clk) begin
		if (en && shift) begin
			value_q <= prev_link.greater ? prev_value : v;
		end
	end

endmodule

[hdl/wms_select.sv]
// picks the entry at rank count/2 from the cell row and registers the result
// depends on wms_pkg
module wms_select #(
	parameter int unsigned MAX_N      = 32,
	parameter int unsigned VALUE_BITS = 16,
	parameter int unsigned CNT_W      = 6,
	parameter int unsigned IDX_W      = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pick,
	input  logic [CNT_W-1:0]      fill,
	input  logic                  dropped,
	input  logic [VALUE_BITS-1:0] store [MAX_N],
	output logic                  done,
	output wms_pkg::out_t         result
);
	import wms_pkg::*;

	logic [CNT_W-1:0] half;
	logic [IDX_W-1:0] rank;
	logic             done_q;
	out_t             result_q;

	assign half = fill >> 1;
	assign rank = IDX_W'(half);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= pick;
		end
	end

	always_ff @(posedge clk) begin
		if (pick) begin
			result_q.median   <= IN_VALUE_W'(store[rank]);
			result_q.count    <= OUT_COUNT_W'(fill);
			result_q.overflow <= dropped;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[hdl/window_median_select_top.sv]
// window median select: per-voxel median core built from a chain of sorting cells
// depends on wms_pkg, wms_cell, wms_select
//
// usage: the feeder presents one neighbour intensity on item with start high;
// it is transferred at a clock edge where start is high and busy is low.
// item.last marks the final neighbour of a voxel. every transfer with room
// inserts the value into a sorted row of MAX_N cells in that same cycle, so
// values go in at one per clock while busy is low. values beyond MAX_N are
// dropped and reported as overflow. after the last item the block is busy
// for one cycle while the entry at rank count/2 is selected; done, registered
// from busy, is then high for one cycle with median, count and overflow on
// result. no item is taken during the rank select. the next voxel may start
// while done is shown. the receiver cannot stall: result is valid only in
// the done cycle. reset clears the fill count, the overflow flag, the pending
// select and done; the cell contents and result are not cleared.
module window_median_select_top #(
	parameter int unsigned MAX_N      = 32,
	parameter int unsigned VALUE_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  wms_pkg::in_t  item,
	output logic          done,
	output wms_pkg::out_t result
);
	import wms_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_N + 1);
	localparam int unsigned IDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;

	logic                  accept;
	logic                  has_room;
	logic                  insert;
	logic [CNT_W-1:0]      count_q;
	logic                  dropped_q;
	logic                  pending_q;
	logic [VALUE_BITS-1:0] v;
	logic [VALUE_BITS-1:0] store [MAX_N];
	link_t                 links [MAX_N];

	assign busy     = pending_q;
	assign accept   = start & ~pending_q;
	assign has_room = count_q < CNT_W'(MAX_N);
	assign insert   = accept & has_room;
	assign v        = VALUE_BITS'(item.value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
			pending_q <= 1'b0;
		end else if (pending_q) begin
			// result picked this cycle, start the next voxel afresh
			count_q   <= '0;
			dropped_q <= 1'b0;
			pending_q <= 1'b0;
		end else if (accept) begin
			if (has_room) begin
				count_q <= count_q + CNT_W'(1);
			end else begin
				dropped_q <= 1'b1;
			end
			pending_q <= item.last;
		end
	end

	for (genvar i = 0; i < MAX_N; i++) begin : g_cell
		link_t                 prev_link;
		logic [VALUE_BITS-1:0] prev_value;
		logic                  occupied;

		assign occupied = count_q > CNT_W'(i);

		if (i == 0) begin : g_head
			assign prev_link.occupied = 1'b1;
			assign prev_link.greater  = 1'b0;
			assign prev_value         = v;
		end else begin : g_body
			assign prev_link  = links[i-1];
			assign prev_value = store[i-1];
		end

		wms_cell #(
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk       (clk),
			.en        (insert),
			.occupied  (occupied),
			.v         (v),
			.prev_link (prev_link),
			.prev_value(prev_value),
			.link      (links[i]),
			.value_q   (store[i])
		);
	end

	wms_select #(
		.MAX_N     (MAX_N),
		.VALUE_BITS(VALUE_BITS),
		.CNT_W     (CNT_W),
		.IDX_W     (IDX_W)
	) u_select (
		.clk    (clk),
		.arst_n (arst_n),
		.pick   (pending_q),
		.fill   (count_q),
		.dropped(dropped_q),
		.store  (store),
		.done   (done),
		.result (result)
	);

endmodule

[hdl/wms_checker.sv]
// port-level checks for window_median_select_top, attached by bind
// depends on wms_pkg and window_median_select_top_assert.svh
`include "window_median_select_top_assert.svh"

module wms_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input wms_pkg::in_t  item,
	input logic          done,
	input wms_pkg::out_t result
);
	import wms_pkg::*;

	// a transfer of the last neighbour is followed by the select cycle
	`WMS_ASSERT_CLK(a_last_busy, clk, arst_n, (start && !busy && item.last) |=> busy, "no select cycle after last transfer")
	// the select cycle lasts one cycle and is followed by the result strobe
	`WMS_ASSERT_CLK(a_busy_done, clk, arst_n, busy |=> (done && !busy), "result strobe missing after select")
	// a result always counts at least one value
	`WMS_ASSERT_CLK(a_count_nz, clk, arst_n, done |-> (result.count != '0), "result with zero count")
	// nothing is strobed while the block is still busy
	`WMS_ASSERT_ALWAYS(a_done_idle, clk, !(done && busy), "done and busy together")

endmodule

bind window_median_select_top wms_checker u_wms_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.item  (item),
	.done  (done),
	.result(result)
);

[bench/tb_window_median_select_top.sv]
// self-checking bench for window_median_select_top: directed table, then random voxels
// depends on wms_pkg and window_median_select_top
`timescale 1ns / 100ps

module tb_window_median_select_top;
	import wms_pkg::*;

	localparam int unsigned SORT_DEPTH  = 32;
	localparam int unsigned CYCLE_LIMIT = 200_000;
	localparam int unsigned PHASE_ITEMS = 275;
	localparam int unsigned N_DIRECTED  = 18;

	typedef struct packed {
		in_t  stim;
		logic typed;
		out_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	in_t  item;
	logic done;
	out_t result;

	// predictor state
	logic [IN_VALUE_W-1:0] sorted_vals [SORT_DEPTH];
	int unsigned           vals_held;
	logic                  vals_dropped;

	out_t        median_due [$];
	int unsigned mismatches;
	int unsigned cycles;

	// rows with typed = 0 are checked against the predictor
	dir_row_t dir_rows [N_DIRECTED] = '{
		'{'{16'h0000, 1'b1}, 1'b1, '{16'h0000, 6'd1, 1'b0}},
		'{'{16'hFFFF, 1'b1}, 1'b1, '{16'hFFFF, 6'd1, 1'b0}},
		'{'{16'h0005, 1'b0}, 1'b0, '0},
		'{'{16'h0003, 1'b1}, 1'b1, '{16'h0005, 6'd2, 1'b0}},
		'{'{16'h0007, 1'b0}, 1'b0, '0},
		'{'{16'h0007, 1'b0}, 1'b0, '0},
		'{'{16'h0007, 1'b1}, 1'b1, '{16'h0007, 6'd3, 1'b0}},
		'{'{16'hFFFF, 1'b0}, 1'b0, '0},
		'{'{16'h0000, 1'b0}, 1'b0, '0},
		'{'{16'h8000, 1'b0}, 1'b0, '0},
		'{'{16'h0001, 1'b1}, 1'b1, '{16'h8000, 6'd4, 1'b0}},
		'{'{16'h0009, 1'b0}, 1'b0, '0},
		'{'{16'h0008, 1'b0}, 1'b0, '0},
		'{'{16'h0007, 1'b0}, 1'b0, '0},
		'{'{16'h0006, 1'b0}, 1'b0, '0},
		'{'{16'h0005, 1'b1}, 1'b0, '0},
		'{'{16'hAAAA, 1'b0}, 1'b0, '0},
		'{'{16'h5555, 1'b1}, 1'b0, '0}
	};

	window_median_select_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string field, input int unsigned got,
			input int unsigned want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
		mismatches++;
	endtask

	// sorted insert, then rank count/2 on the final neighbour
	task automatic median_predict(input in_t it, output logic emits, output out_t r);
		int unsigned pos;
		int unsigned rank;
		emits = 1'b0;
		r = '0;
		if (vals_held < SORT_DEPTH) begin
			pos = vals_held;
			while (pos > 0 && sorted_vals[pos-1] > it.value) begin
				sorted_vals[pos] = sorted_vals[pos-1];
				pos--;
			end
			sorted_vals[pos] = it.value;
			vals_held++;
		end else begin
			vals_dropped = 1'b1;
		end
		if (it.last) begin
			rank = vals_held / 2;
			if (rank >= SORT_DEPTH)
				rank = SORT_DEPTH - 1;
			r.median   = sorted_vals[rank];
			r.count    = vals_held[OUT_COUNT_W-1:0];
			r.overflow = vals_dropped;
			emits = 1'b1;
			vals_held = 0;
			vals_dropped = 1'b0;
		end
	endtask

	// entered and left at a falling edge
	task automatic send_neighbour(input in_t it, input int unsigned idle_pct,
			input logic typed, input out_t want);
		logic emits;
		out_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			item  <= in_t'($urandom);
			@(negedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy !== 1'b0);
		median_predict(it, emits, predicted);
		if (emits)
			median_due.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	function automatic logic [IN_VALUE_W-1:0] pick_value(input int unsigned mode,
			input logic [IN_VALUE_W-1:0] base);
		case (mode)
			0: return IN_VALUE_W'($urandom);
			1: return IN_VALUE_W'($urandom_range(3));
			2: begin
				case ($urandom_range(2))
					0: return '0;
					1: return '1;
					default: return IN_VALUE_W'($urandom);
				endcase
			end
			default: return base + IN_VALUE_W'($urandom_range(15));
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		out_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (median_due.size() == 0) begin
				report_mismatch("unexpected result, median", result.median, 0);
			end else begin
				want = median_due.pop_front();
				if (result.median !== want.median)
					report_mismatch("median", result.median, want.median);
				if (result.count !== want.count)
					report_mismatch("count", result.count, want.count);
				if (result.overflow !== want.overflow)
					report_mismatch("overflow", result.overflow, want.overflow);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned phase_pct [4] = '{0, 81, 29, 0};
		int unsigned sent;
		int unsigned len;
		int unsigned mode;
		int unsigned sel;
		logic [IN_VALUE_W-1:0] base;
		in_t it;
		cycles = 0;
		mismatches = 0;
		vals_held = 0;
		vals_dropped = 1'b0;
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_neighbour(dir_rows[i].stim, 0, dir_rows[i].typed, dir_rows[i].want);

		// random voxels: mostly short, some exactly full, some over capacity
		for (int p = 0; p < 4; p++) begin
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				sel = $urandom_range(99);
				if (sel < 50)
					len = $urandom_range(8, 1);
				else if (sel < 80)
					len = $urandom_range(31, 9);
				else if (sel < 90)
					len = SORT_DEPTH;
				else
					len = $urandom_range(SORT_DEPTH + 8, SORT_DEPTH + 1);
				mode = $urandom_range(3);
				base = IN_VALUE_W'($urandom);
				for (int unsigned k = 0; k < len; k++) begin
					it.value = pick_value(mode, base);
					it.last  = (k == len - 1);
					send_neighbour(it, phase_pct[p], 1'b0, '0);
				end
				sent += len;
			end
		end

		start <= 1'b0;
		while (median_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/wms_pkg.sv
hdl/wms_cell.sv
hdl/wms_select.sv
hdl/window_median_select_top.sv
hdl/wms_checker.sv
bench/tb_window_median_select_top.sv
